### rtl/irctok_pkg.sv
// IRC message tokenizer: shared types, codes and character helpers.
// No dependencies; imported by irc_message_tokenizer_core.
package irctok_pkg;

  localparam int unsigned MaxParamsDef = 15;

  localparam int unsigned CharW  = 8;
  localparam int unsigned CountW = 4;

  localparam logic [CharW-1:0] ChNul   = 8'h00;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChColon = 8'h3A;

  // command_progress codes: 1..3 digits seen, or letters only
  localparam logic [2:0] CmdNone   = 3'd0;
  localparam logic [2:0] CmdOne    = 3'd1;
  localparam logic [2:0] CmdDigits = 3'd3;
  localparam logic [2:0] CmdAlpha  = 3'd4;

  typedef enum logic [2:0] {
    PhStart     = 3'd0,
    PhPrefix    = 3'd1,
    PhCommand   = 3'd2,
    PhGap       = 3'd3,
    PhParam     = 3'd4,
    PhTrailOpen = 3'd5,
    PhTrail     = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    TokSep    = 2'd0,
    TokPrefix = 2'd1,
    TokCmd    = 2'd2,
    TokParam  = 2'd3
  } tok_class_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StOkPrefix = 2'd1,
    StError    = 2'd2
  } status_e;

  // result item, first field in the highest bits
  typedef struct packed {
    logic [CountW-1:0] param_count;
    status_e           status;
    logic              token_start;
    logic [CountW-1:0] param_index;
    tok_class_e        token_class;
  } result_t;

  function automatic logic is_digit(input logic [CharW-1:0] c);
    is_digit = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [CharW-1:0] c);
    is_alpha = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

endpackage

### rtl/irc_message_tokenizer_core.sv
// IRC message tokenizer, top level: per-byte classification and message status.
// Depends on irctok_pkg.
//
// Usage: message bytes enter on the s_axis channel, one item per byte; a zero
// byte terminates the message. Every byte yields exactly one result item on
// m_axis: token class, parameter index and token-start mark in tdata. The
// terminator's result has tlast high and carries status and parameter count.
// Latency: the result of a byte is presented the cycle after it is accepted.
// Throughput: one byte per cycle while the receiver keeps up; the per-byte parse step is a small state
// update between the accepting edge and the result register.
// Stall: while a result waits, a new byte is still taken if the receiver takes
// the waiting one in the same cycle; otherwise s_axis_tready drops and the
// result holds.
// Reset: parser returns to message start, result register empties. After each
// terminator the parser clears itself for the next message.
module irc_message_tokenizer_core #(
  parameter int unsigned MAX_PARAMS = irctok_pkg::MaxParamsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [1:0] token_class, [5:2] param_index,
                                      // [6] token_start, [8:7] status,
                                      // [12:9] param_count, [15:13] zero
  output logic        m_axis_tlast    // message_end
);
  import irctok_pkg::*;

  localparam logic [CountW-1:0] MaxParams = CountW'(MAX_PARAMS);

  phase_e            phase_q, phase_d;
  logic [2:0]        cmd_q, cmd_d;
  logic [CountW-1:0] params_q, params_d;
  logic              prefix_q, prefix_d;
  logic              err_q, err_d;

  result_t           res_d, res_q;
  logic              last_d, last_q;
  logic              out_valid_q;
  logic              in_fire;
  logic              bad;
  logic              cmd_done;
  logic [CharW-1:0]  c;

  assign c             = s_axis_tdata;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cmd_done      = (cmd_q == CmdAlpha) || (cmd_q == CmdDigits);

  always_comb begin
    phase_d  = phase_q;
    cmd_d    = cmd_q;
    params_d = params_q;
    prefix_d = prefix_q;
    err_d    = err_q;
    res_d    = '0;
    last_d   = 1'b0;
    bad      = err_q;

    if (c == ChNul) begin
      if (!err_q) begin
        case (phase_q)
          PhCommand: bad = !cmd_done;
          PhGap, PhParam, PhTrailOpen, PhTrail: bad = 1'b0;
          default: bad = 1'b1;
        endcase
      end
      last_d            = 1'b1;
      res_d.status      = bad ? StError : (prefix_q ? StOkPrefix : StOk);
      res_d.param_count = bad ? '0 : params_q;
      phase_d           = PhStart;
      cmd_d             = CmdNone;
      params_d          = '0;
      prefix_d          = 1'b0;
      err_d             = 1'b0;
    end else if (!err_q) begin
      case (phase_q)
        PhPrefix: begin
          if (c == ChSpace) begin
            if (cmd_q == CmdNone) err_d = 1'b1;
            else phase_d = PhStart;
          end else begin
            res_d.token_class = TokPrefix;
            res_d.token_start = (cmd_q == CmdNone);
            cmd_d             = CmdOne;
          end
        end
        PhCommand: begin
          if (c == ChSpace) begin
            if (!cmd_done) err_d = 1'b1;
            else phase_d = PhGap;
          end else if (cmd_q == CmdAlpha) begin
            if (is_alpha(c)) res_d.token_class = TokCmd;
            else err_d = 1'b1;
          end else if (cmd_q < CmdDigits && is_digit(c)) begin
            cmd_d             = cmd_q + 3'd1;
            res_d.token_class = TokCmd;
          end else begin
            err_d = 1'b1;
          end
        end
        PhGap, PhTrailOpen: begin
          if (c == ChSpace) begin
            // separator, nothing to do
          end else if (c == ChColon && phase_q == PhGap) begin
            phase_d = PhTrailOpen;
          end else if (params_q >= MaxParams) begin
            err_d = 1'b1;
          end else begin
            res_d.token_class = TokParam;
            res_d.param_index = params_q;
            res_d.token_start = 1'b1;
            params_d          = params_q + CountW'(1);
            phase_d           = (phase_q == PhGap) ? PhParam : PhTrail;
          end
        end
        PhParam: begin
          if (c == ChSpace) begin
            phase_d = PhGap;
          end else begin
            res_d.token_class = TokParam;
            res_d.param_index = params_q - CountW'(1);
          end
        end
        PhTrail: begin
          res_d.token_class = TokParam;
          res_d.param_index = params_q - CountW'(1);
        end
        default: begin
          // message start; unused codes fold in here
          phase_d = PhStart;
          if (c == ChSpace) begin
            // leading space skipped
          end else if (c == ChColon && !prefix_q) begin
            prefix_d = 1'b1;
            cmd_d    = CmdNone;
            phase_d  = PhPrefix;
          end else if (is_digit(c)) begin
            cmd_d             = CmdOne;
            phase_d           = PhCommand;
            res_d.token_class = TokCmd;
            res_d.token_start = 1'b1;
          end else if (is_alpha(c)) begin
            cmd_d             = CmdAlpha;
            phase_d           = PhCommand;
            res_d.token_class = TokCmd;
            res_d.token_start = 1'b1;
          end else begin
            err_d = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhStart;
      cmd_q    <= CmdNone;
      params_q <= '0;
      prefix_q <= 1'b0;
      err_q    <= 1'b0;
    end else if (in_fire) begin
      phase_q  <= phase_d;
      cmd_q    <= cmd_d;
      params_q <= params_d;
      prefix_q <= prefix_d;
      err_q    <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q  <= res_d;
      last_q <= last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_q};
  assign m_axis_tlast  = last_q;

  // terminator clears the parser for the next message
  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (s_axis_tdata == ChNul) |=> (phase_q == PhStart) && (params_q == '0)
      && !err_q && !prefix_q)
    else $error("parser not cleared after terminator");

  // status and count only on the terminator's result
  a_status_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> (res_q.status == StOk) && (res_q.param_count == '0))
    else $error("status or count outside message end");

  // an errored message reports no parameters
  a_error_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast && (res_q.status == StError) |-> res_q.param_count == '0)
    else $error("error status with non-zero count");

  // terminator result is a plain separator
  a_end_is_sep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> (res_q.token_class == TokSep) && !res_q.token_start)
    else $error("terminator result tagged as token");

  // parameter count never exceeds the limit
  a_param_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    params_q <= MaxParams)
    else $error("parameter count beyond limit");

endmodule
